[hdl/assert_macros.svh]
// Assertion macros shared by the hash table RTL.
// Depends on: i_clk and i_rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define RHHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define RHHT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[hdl/rhht_pkg.sv]
// Shared constants and types of the hash table.
// Depends on nothing; rhht_hash, rhht_front, rhht_engine and the top refer to it by scoped names.
`default_nettype none

package rhht_pkg;

    localparam int TABLE_BITS  = 12;
    localparam int HANDLE_BITS = 16;
    localparam int TABLE_SIZE  = 1 << TABLE_BITS;
    // stored handle width: masked to HANDLE_BITS, ports carry at most 16
    localparam int H_BITS      = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int KEY_W       = 64;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic [63:0] MIX_CONST = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_EVAL  = 2'd3
    } t_eng_state;

    typedef struct packed {
        t_cmd                  cmd;
        logic [KEY_W-1:0]      key;
        logic [H_BITS-1:0]     first;
        logic [H_BITS-1:0]     second;
        logic [TABLE_BITS-1:0] home;
    } t_item;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [TABLE_BITS-1:0] home;
        logic [H_BITS-1:0]     first;
        logic [H_BITS-1:0]     second;
    } t_slot;

    typedef struct packed {
        logic        found;
        logic [15:0] first;
        logic [15:0] second;
        logic        placed;
    } t_result;

endpackage

`default_nettype wire

[hdl/rhht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rhht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/rhht_hash.sv]
// Home-slot hash: bits 32 and up of key * MIX_CONST, two pipeline stages.
// Depends on rhht_pkg.
`default_nettype none

module rhht_hash (
    input  wire logic                              i_clk,
    input  wire logic [rhht_pkg::KEY_W-1:0]        i_key,
    output logic      [rhht_pkg::TABLE_BITS-1:0]   o_home
);

    // only product bits 47:0 matter; split into 24-bit halves
    logic [23:0] w_kl, w_kh, w_cl, w_ch;
    logic [47:0] w_p0, w_p1, w_p2;
    logic [47:0] r_pp0;
    logic [23:0] r_pp1, r_pp2;
    logic [23:0] w_cross;
    logic [47:0] w_sum;
    logic [rhht_pkg::TABLE_BITS-1:0] r_home;

    assign w_kl = i_key[23:0];
    assign w_kh = i_key[47:24];
    assign w_cl = rhht_pkg::MIX_CONST[23:0];
    assign w_ch = rhht_pkg::MIX_CONST[47:24];

    assign w_p0 = w_kl * w_cl;
    assign w_p1 = w_kh * w_cl;
    assign w_p2 = w_kl * w_ch;

    always_ff @(posedge i_clk) begin
        r_pp0 <= w_p0;
        r_pp1 <= w_p1[23:0];
        r_pp2 <= w_p2[23:0];
    end

    // cross terms only reach bits 47:24
    assign w_cross = r_pp1 + r_pp2;
    assign w_sum   = r_pp0 + {w_cross, 24'd0};

    always_ff @(posedge i_clk) begin
        r_home <= w_sum[32 +: rhht_pkg::TABLE_BITS];
    end

    assign o_home = r_home;

endmodule

`default_nettype wire

[hdl/rhht_front.sv]
// Front end: takes requests, computes the home slot, buffers in a short queue.
// Depends on rhht_pkg, rhht_hash and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhht_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_push,
    output logic                                o_full,
    input  wire rhht_pkg::t_cmd                 i_cmd,
    input  wire logic [rhht_pkg::KEY_W-1:0]     i_key,
    input  wire logic [15:0]                    i_first,
    input  wire logic [15:0]                    i_second,
    output rhht_pkg::t_item                     o_item,
    output logic                                o_item_vld,
    input  wire logic                           i_item_pop
);

    localparam int QD = rhht_pkg::QDEPTH;
    localparam int PW = rhht_pkg::QPTR_W;

    logic                               r_v1, r_v2;
    rhht_pkg::t_item                    r_it1, r_it2;
    rhht_pkg::t_item                    w_in, w_qin;
    logic [rhht_pkg::TABLE_BITS-1:0]    w_home;
    rhht_pkg::t_item                    r_q [QD];
    logic [PW-1:0]                      r_wp, r_rp;
    logic [PW:0]                        r_count;
    logic [PW+1:0]                      w_reserved;

    rhht_hash u_hash (
        .i_clk  (i_clk),
        .i_key  (i_key),
        .o_home (w_home)
    );

    always_comb begin
        w_in        = '0;
        w_in.cmd    = i_cmd;
        w_in.key    = i_key;
        w_in.first  = i_first[rhht_pkg::H_BITS-1:0];
        w_in.second = i_second[rhht_pkg::H_BITS-1:0];
    end

    always_comb begin
        w_qin      = r_it2;
        w_qin.home = w_home;
    end

    // queue slots already promised to items in the hash pipe count as used
    assign w_reserved = (PW+2)'(r_count) + (PW+2)'(r_v1) + (PW+2)'(r_v2);
    assign o_full     = (w_reserved >= (PW+2)'(QD));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_item_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (PW+1)'(r_v2) - (PW+1)'(i_item_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_it1 <= w_in;
        r_it2 <= r_it1;
        if (r_v2) begin
            r_q[r_wp] <= w_qin;
        end
    end

    assign o_item     = r_q[r_rp];
    assign o_item_vld = (r_count != '0);

    `RHHT_ASSERT(a_reserved_bound, w_reserved <= (PW+2)'(QD), "front queue overcommitted")
    `RHHT_NEVER(a_pop_empty, i_item_pop && (r_count == '0), "pop from empty front queue")

endmodule

`default_nettype wire

[hdl/rhht_engine.sv]
// Back end: probe sequencer over the slot RAM, clearing sweep, result register.
// Depends on rhht_pkg, rhht_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rhht_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire rhht_pkg::t_item    i_item,
    input  wire logic               i_item_vld,
    output logic                    o_item_pop,
    input  wire logic               i_pop,
    output rhht_pkg::t_result       o_res,
    output logic                    o_res_vld,
    output logic                    o_init_busy
);

    localparam int TB = rhht_pkg::TABLE_BITS;

    rhht_pkg::t_eng_state       r_state, n_state;
    logic [TB:0]                r_addr;
    rhht_pkg::t_cmd             r_cmd;
    rhht_pkg::t_slot            r_carry;
    logic                       r_clr_cmd;
    rhht_pkg::t_result          r_res, w_res;
    logic                       r_res_vld;

    rhht_pkg::t_slot            w_slot, w_wdata;
    logic [$bits(rhht_pkg::t_slot)-1:0] w_rdata;
    logic                       w_we;
    logic                       w_match, w_empty, w_stop, w_swap, w_end, w_done;
    logic                       w_clr_last, w_start, w_res_set;
    logic [TB:0]                w_next;

    rhht_ram #(
        .WIDTH ($bits(rhht_pkg::t_slot)),
        .DEPTH (rhht_pkg::TABLE_SIZE)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr[TB-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_addr[TB-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_slot     = rhht_pkg::t_slot'(w_rdata);
    assign w_match    = (w_slot.key == r_carry.key);
    assign w_empty    = (w_slot.first == '0);
    assign w_stop     = w_match || w_empty;
    // resident homed further on gives way to the carried item
    assign w_swap     = !w_stop && (w_slot.home > r_carry.home);
    assign w_next     = r_addr + 1'b1;
    assign w_end      = w_next[TB];
    assign w_done     = w_stop || w_end;
    assign w_clr_last = (r_addr[TB-1:0] == '1);
    assign w_start    = (r_state == rhht_pkg::ST_IDLE) && i_item_vld && (!r_res_vld || i_pop);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rhht_pkg::ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = rhht_pkg::ST_IDLE;
                end
            end
            rhht_pkg::ST_IDLE: begin
                if (w_start) begin
                    unique case (i_item.cmd) inside
                        rhht_pkg::CMD_INSERT,
                        rhht_pkg::CMD_LOOKUP: n_state = rhht_pkg::ST_READ;
                        rhht_pkg::CMD_CLEAR:  n_state = rhht_pkg::ST_CLEAR;
                        default:              n_state = rhht_pkg::ST_IDLE;
                    endcase
                end
            end
            rhht_pkg::ST_READ: n_state = rhht_pkg::ST_EVAL;
            rhht_pkg::ST_EVAL: begin
                n_state = w_done ? rhht_pkg::ST_IDLE : rhht_pkg::ST_READ;
            end
            default: n_state = rhht_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_item_pop = w_start;
        w_we       = 1'b0;
        w_wdata    = r_carry;
        w_res_set  = 1'b0;
        w_res      = '0;
        unique case (r_state)
            rhht_pkg::ST_CLEAR: begin
                w_we      = 1'b1;
                w_wdata   = '0;
                w_res_set = w_clr_last && r_clr_cmd;
            end
            rhht_pkg::ST_IDLE: begin
                w_res_set = w_start && (i_item.cmd == rhht_pkg::CMD_NOP);
            end
            rhht_pkg::ST_READ: begin
                w_we = 1'b0;
            end
            rhht_pkg::ST_EVAL: begin
                w_res_set = w_done;
                if (r_cmd == rhht_pkg::CMD_INSERT) begin
                    w_we         = w_stop || w_swap;
                    w_res.placed = w_stop;
                end else if (w_stop) begin
                    w_res.found  = w_match && !w_empty;
                    w_res.first  = 16'(w_slot.first);
                    w_res.second = 16'(w_slot.second);
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rhht_pkg::ST_CLEAR;
            r_addr    <= '0;
            r_clr_cmd <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_clr_cmd <= (i_item.cmd == rhht_pkg::CMD_CLEAR);
                r_addr    <= (i_item.cmd == rhht_pkg::CMD_CLEAR) ? '0 : {1'b0, i_item.home};
            end else if (r_state == rhht_pkg::ST_CLEAR || r_state == rhht_pkg::ST_EVAL) begin
                r_addr <= w_next;
            end
            if (i_pop && r_res_vld) begin
                r_res_vld <= 1'b0;
            end
            if (w_res_set) begin
                r_res_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cmd          <= i_item.cmd;
            r_carry.key    <= i_item.key;
            r_carry.home   <= i_item.home;
            r_carry.first  <= i_item.first;
            r_carry.second <= i_item.second;
        end else if (r_state == rhht_pkg::ST_EVAL && r_cmd == rhht_pkg::CMD_INSERT && w_swap) begin
            r_carry <= w_slot;
        end
        if (w_res_set) begin
            r_res <= w_res;
        end
    end

    assign o_res       = r_res;
    assign o_res_vld   = r_res_vld;
    assign o_init_busy = (r_state == rhht_pkg::ST_CLEAR) && !r_clr_cmd;

    `RHHT_ASSERT(a_probe_range,
        (r_state == rhht_pkg::ST_READ || r_state == rhht_pkg::ST_EVAL) |-> !r_addr[TB],
        "probe address past table end")
    `RHHT_ASSERT(a_res_free, w_res_set |-> (!r_res_vld || i_pop),
        "result overwrites an unread result")

endmodule

`default_nettype wire

[hdl/robin_hood_hash_table_top.sv]
// Top level of the Robin Hood hash table: queue-style request and result ports.
// Depends on rhht_pkg, rhht_front and rhht_engine.
`default_nettype none

// Open-addressed hash table of 4096 slots (TABLE_BITS in rhht_pkg), each a
// 64-bit key and two handles, probed linearly with Robin Hood displacement.
// Requests enter through push/full, results leave through empty/pop, one
// result per request in request order. After reset the slot RAM is swept to
// zero, one slot per cycle; full stays high during that sweep.
// A request first passes through the front end (the registered home-slot
// multiply, then a four-entry queue), which overlaps with earlier work.
// The back end then handles an insert or lookup one probe at a time: each
// probe is one read of the single-port-read slot RAM (ST_READ) and one
// compare step (ST_EVAL) that, on insert, writes back or swaps. A clear
// request zeroes every slot. Until full, the queue keeps accepting requests
// while the back end probes or a result waits to be popped.
module robin_hood_hash_table_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_command,
    input  wire logic [63:0] i_key,
    input  wire logic [15:0] i_first_handle,
    input  wire logic [15:0] i_second_handle,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic             o_found,
    output logic [15:0]      o_first_out,
    output logic [15:0]      o_second_out,
    output logic             o_placed
);

    logic               w_front_full;
    logic               w_init_busy;
    logic               w_push;
    rhht_pkg::t_item    w_item;
    logic               w_item_vld;
    logic               w_item_pop;
    rhht_pkg::t_result  w_res;
    logic               w_res_vld;

    // no request is taken while the post-reset sweep runs
    assign o_full = w_front_full || w_init_busy;
    assign w_push = i_push && !o_full;

    rhht_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_full     (w_front_full),
        .i_cmd      (rhht_pkg::t_cmd'(i_command)),
        .i_key      (i_key),
        .i_first    (i_first_handle),
        .i_second   (i_second_handle),
        .o_item     (w_item),
        .o_item_vld (w_item_vld),
        .i_item_pop (w_item_pop)
    );

    rhht_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_item_vld  (w_item_vld),
        .o_item_pop  (w_item_pop),
        .i_pop       (i_pop),
        .o_res       (w_res),
        .o_res_vld   (w_res_vld),
        .o_init_busy (w_init_busy)
    );

    assign o_empty      = !w_res_vld;
    assign o_found      = w_res.found;
    assign o_first_out  = w_res.first;
    assign o_second_out = w_res.second;
    assign o_placed     = w_res.placed;

endmodule

`default_nettype wire

[tb/sv/robin_hood_hash_table_top_tb.sv]
// Testbench for robin_hood_hash_table_top: queue-style request and result ports.
// Depends on rhht_pkg and the RTL; keeps its own mirror of the slot table to
// predict every result.
`default_nettype none

module robin_hood_hash_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhht_pkg::*;

    localparam int SLOTS = TABLE_SIZE + 1;  // last slot is the overflow slot, never filled
    localparam logic [15:0] HANDLE_MASK = 16'hFFFF >> (16 - H_BITS);
    localparam int ITEM_TARGET = 1400;

    // Mirror of the slot table plus the queue of results still owed by the block.
    class slot_mirror;
        logic [63:0] slot_key    [SLOTS];
        logic [15:0] slot_first  [SLOTS];
        logic [15:0] slot_second [SLOTS];
        t_result     due_results [$];
        int          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < SLOTS; i++) begin
                slot_key[i]    = '0;
                slot_first[i]  = '0;
                slot_second[i] = '0;
            end
        endfunction

        function int home_slot(logic [63:0] key);
            logic [63:0] prod;
            prod = key * MIX_CONST;
            return int'(prod[32 +: TABLE_BITS]);
        endfunction

        // Linear probe with Robin Hood displacement; 0 when the carried item
        // falls off the end of the table.
        function bit predict_insert(logic [63:0] key, logic [15:0] h1, logic [15:0] h2);
            logic [63:0] k, rk;
            logic [15:0] f, s, rf, rs;
            int home, rhome;
            k = key;
            f = h1;
            s = h2;
            home = home_slot(k);
            for (int b = home; b < TABLE_SIZE; b++) begin
                if (slot_key[b] == k || slot_first[b] == '0) begin
                    slot_key[b]    = k;
                    slot_first[b]  = f;
                    slot_second[b] = s;
                    return 1'b1;
                end
                rhome = home_slot(slot_key[b]);
                if (rhome > home) begin
                    rk = slot_key[b];
                    rf = slot_first[b];
                    rs = slot_second[b];
                    slot_key[b]    = k;
                    slot_first[b]  = f;
                    slot_second[b] = s;
                    k    = rk;
                    f    = rf;
                    s    = rs;
                    home = rhome;
                end
            end
            return 1'b0;
        endfunction

        function t_result predict_lookup(logic [63:0] key);
            t_result r;
            int b;
            r = '0;
            b = home_slot(key);
            while (b < TABLE_SIZE && slot_key[b] != key && slot_first[b] != '0)
                b++;
            if (b < TABLE_SIZE) begin
                r.found  = (slot_first[b] != '0) && (slot_key[b] == key);
                r.first  = slot_first[b];
                r.second = slot_second[b];
            end
            return r;
        endfunction

        function void note_request(t_cmd cmd, logic [63:0] key, logic [15:0] h1,
                                   logic [15:0] h2);
            t_result r;
            r = '0;
            case (cmd)
                CMD_INSERT: r.placed = predict_insert(key, h1 & HANDLE_MASK, h2 & HANDLE_MASK);
                CMD_LOOKUP: r = predict_lookup(key);
                CMD_CLEAR:  wipe();
                default:    ;
            endcase
            due_results.push_back(r);
        endfunction

        // One line per mismatch; printing stops after 100 lines, counting does not.
        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_result(logic found, logic [15:0] first, logic [15:0] second,
                          logic placed);
            t_result want;
            if (due_results.size() == 0) begin
                report("result popped with no request outstanding");
                return;
            end
            want = due_results.pop_front();
            if (found !== want.found)
                report($sformatf("found %b, expected %b", found, want.found));
            if (first !== want.first)
                report($sformatf("first_out %h, expected %h", first, want.first));
            if (second !== want.second)
                report($sformatf("second_out %h, expected %h", second, want.second));
            if (placed !== want.placed)
                report($sformatf("placed %b, expected %b", placed, want.placed));
        endtask
    endclass

    // ---------------------------------------------------------------- signals
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_push          = 1'b0;
    logic [1:0]  i_command       = CMD_NOP;
    logic [63:0] i_key           = '0;
    logic [15:0] i_first_handle  = '0;
    logic [15:0] i_second_handle = '0;
    logic        i_pop           = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic        o_found;
    logic [15:0] o_first_out;
    logic [15:0] o_second_out;
    logic        o_placed;

    slot_mirror  mirror;
    logic [63:0] mix_inv;      // multiplicative inverse of MIX_CONST mod 2^64
    int          burst_left;   // requests left in the current sender burst
    logic [15:0] pop_pattern = '1;
    int          pattern_age = 0;

    robin_hood_hash_table_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_command       (i_command),
        .i_key           (i_key),
        .i_first_handle  (i_first_handle),
        .i_second_handle (i_second_handle),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_found         (o_found),
        .o_first_out     (o_first_out),
        .o_second_out    (o_second_out),
        .o_placed        (o_placed)
    );

    always #10 i_clk = ~i_clk;

    // The hash multiplier is odd, hence invertible: picking the product with
    // the wanted home bits and multiplying by the inverse yields a key that
    // lands on that home. Everything outside the home bits stays random.
    function automatic logic [63:0] key_with_home(int home);
        logic [63:0] m;
        logic [31:0] hi, lo;
        hi = $urandom;
        lo = $urandom;
        m = {hi, lo};
        m[32 +: TABLE_BITS] = home[TABLE_BITS-1:0];
        return m * mix_inv;
    endfunction

    function automatic logic [63:0] any_key();
        logic [31:0] hi, lo;
        hi = $urandom;
        lo = $urandom;
        return {hi, lo};
    endfunction

    // Present one request and hold it until accepted. The sender runs in
    // bursts; between most bursts push drops for a random pause. push
    // is never lowered at the accepting edge when the next request follows
    // straight away, so each edge sees at most one write to it.
    task automatic send_request(t_cmd cmd, logic [63:0] key, logic [15:0] h1,
                                logic [15:0] h2);
        int gap;
        i_push          <= 1'b1;
        i_command       <= cmd;
        i_key           <= key;
        i_first_handle  <= h1;
        i_second_handle <= h2;
        @(posedge i_clk);
        while (o_full !== 1'b0)
            @(posedge i_clk);
        mirror.note_request(cmd, key, h1, h2);
        burst_left--;
        if (burst_left <= 0) begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Result side: check on every accepted pop, then drive pop from a rotating
    // stall pattern that is redrawn at random intervals. Patterns range
    // from all ones (no stalls) to sparse, but always keep at least one bit.
    always @(posedge i_clk) begin : pop_driver
        logic [15:0] next_pat;
        logic [31:0] rnd;
        if (i_rst_n && i_pop && o_empty === 1'b0)
            mirror.check_result(o_found, o_first_out, o_second_out, o_placed);
        next_pat = {pop_pattern[0], pop_pattern[15:1]};
        if (pattern_age == 0) begin
            rnd = $urandom;
            case ($urandom_range(0, 3))
                0:       next_pat = '1;
                1:       next_pat = (rnd[15:0] & rnd[31:16]) | 16'h0001;
                default: next_pat = rnd[15:0] | 16'h0001;
            endcase
        end
        pattern_age <= (pattern_age == 0) ? $urandom_range(50, 400) : pattern_age - 1;
        pop_pattern <= next_pat;
        i_pop       <= next_pat[0];
    end

    // Hard stop; a correct run ends well before this.
    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] k_zero, k_ones, k_null;
        logic [63:0] k_next, k_home_a, k_home_b;   // Robin Hood swap trio
        logic [63:0] k_end_a, k_end_b, k_pen_a, k_pen_b;  // keys near the table end
        logic [63:0] key;
        logic [63:0] key_pool [$];
        logic [31:0] rnd;
        logic [15:0] h1, h2;
        t_cmd        cmd;
        int          items, width, base, pool_n, pick;
        bit          near_end;

        mirror = new();
        mix_inv = MIX_CONST;
        repeat (5) mix_inv = mix_inv * (64'd2 - MIX_CONST * mix_inv);
        burst_left = 1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------------------------------------------- directed part
        k_zero   = '0;
        k_ones   = '1;
        k_null   = key_with_home(37);
        k_next   = key_with_home(101);
        k_home_a = key_with_home(100);
        k_home_b = key_with_home(100);
        k_end_a  = key_with_home(TABLE_SIZE - 1);
        k_end_b  = key_with_home(TABLE_SIZE - 1);
        k_pen_a  = key_with_home(TABLE_SIZE - 2);
        k_pen_b  = key_with_home(TABLE_SIZE - 2);

        // empty table, then the extreme keys and handles
        send_request(CMD_LOOKUP, k_zero, 16'h0000, 16'h0000);
        send_request(CMD_INSERT, k_zero, 16'hFFFF, 16'hFFFF);
        send_request(CMD_LOOKUP, k_zero, 16'h0000, 16'h0000);
        send_request(CMD_INSERT, k_ones, 16'h0001, 16'h0000);
        send_request(CMD_LOOKUP, k_ones, 16'hFFFF, 16'hFFFF);
        // equal key overwrites in place
        send_request(CMD_INSERT, k_zero, 16'h1234, 16'h5678);
        send_request(CMD_LOOKUP, k_zero, 16'h0000, 16'h0000);
        // zero first handle: written, but the slot still reads as empty
        send_request(CMD_INSERT, k_null, 16'h0000, 16'hABCD);
        send_request(CMD_LOOKUP, k_null, 16'h0000, 16'h0000);
        // unused command leaves the table alone
        send_request(CMD_NOP, k_ones, 16'hFFFF, 16'hFFFF);
        send_request(CMD_LOOKUP, k_ones, 16'h0000, 16'h0000);
        // resident whose home lies beyond gets pushed one slot on
        send_request(CMD_INSERT, k_next, 16'h0101, 16'h0202);
        send_request(CMD_INSERT, k_home_a, 16'h0303, 16'h0404);
        send_request(CMD_INSERT, k_home_b, 16'h0505, 16'h0606);
        send_request(CMD_LOOKUP, k_next, 16'h0000, 16'h0000);
        send_request(CMD_LOOKUP, k_home_b, 16'h0000, 16'h0000);
        // table end: the swap pushes a resident off the end and drops it,
        // a lookup then runs into the overflow slot, a plain insert fails
        send_request(CMD_INSERT, k_end_a, 16'h0A0A, 16'h0B0B);
        send_request(CMD_INSERT, k_pen_a, 16'h0C0C, 16'h0D0D);
        send_request(CMD_INSERT, k_pen_b, 16'h0E0E, 16'h0F0F);
        send_request(CMD_LOOKUP, k_end_a, 16'h0000, 16'h0000);
        send_request(CMD_INSERT, k_end_b, 16'h7777, 16'h8888);
        // clear wipes everything
        send_request(CMD_CLEAR, k_ones, 16'hFFFF, 16'hFFFF);
        send_request(CMD_LOOKUP, k_zero, 16'h0000, 16'h0000);
        send_request(CMD_LOOKUP, k_pen_a, 16'h0000, 16'h0000);

        // ------------------------------------------------------ random part
        // Phases of requests on a small key pool whose homes crowd into one
        // narrow window, so clusters grow long, swaps happen and, near the
        // end of the table, inserts overflow. A fifth of keys are fresh.
        items = 0;
        while (items < ITEM_TARGET) begin
            near_end = ($urandom_range(0, 9) < 3);
            width    = $urandom_range(1, 32);
            base     = near_end ? TABLE_SIZE - width : $urandom_range(0, TABLE_SIZE - width);
            pool_n   = $urandom_range(4, 48);
            key_pool.delete();
            repeat (pool_n)
                key_pool.push_back(key_with_home(base + $urandom_range(0, width - 1)));
            // clearing before end phases keeps the end cluster bounded
            if (near_end || $urandom_range(0, 9) < 4)
                send_request(CMD_CLEAR, any_key(), 16'h0000, 16'h0000);
            repeat ($urandom_range(50, 150)) begin
                pick = $urandom_range(0, 999);
                key  = ($urandom_range(0, 4) == 0) ? any_key()
                                                   : key_pool[$urandom_range(0, pool_n - 1)];
                rnd  = $urandom;
                h1   = rnd[15:0];
                h2   = rnd[31:16];
                case ($urandom_range(0, 19))
                    0:       h1 = '0;
                    1:       h1 = '1;
                    default: ;
                endcase
                if (pick < 470)
                    cmd = CMD_INSERT;
                else if (pick < 970)
                    cmd = CMD_LOOKUP;
                else if (pick < 995)
                    cmd = CMD_NOP;
                else
                    cmd = CMD_CLEAR;
                send_request(cmd, key, h1, h2);
                items++;
            end
        end

        // ------------------------------------------------------------ drain
        i_push <= 1'b0;
        while (mirror.due_results.size() != 0)
            @(posedge i_clk);
        repeat (32) @(posedge i_clk);
        if (mirror.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hdl
hdl/rhht_pkg.sv
hdl/rhht_ram.sv
hdl/rhht_hash.sv
hdl/rhht_front.sv
hdl/rhht_engine.sv
hdl/robin_hood_hash_table_top.sv
tb/sv/robin_hood_hash_table_top_tb.sv
